// File: sv/circular_deque_top_assert.svh
// Assertion macros used by the circular deque datapath.
`ifndef CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_TOP_ASSERT_SVH

// Check an implication in the same cycle, sampled on clock, idle in reset.
`define CDQ_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("circular deque check failed");

// Check an implication in the next cycle, sampled on clock, idle in reset.
`define CDQ_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("circular deque check failed");

`endif

// File: sv/cdq_pkg.sv
// Shared constants, types and codes of the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int DEPTH    = 8;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH_HEAD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_HEAD  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_TAIL  = 3'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_OP   = 4'b0010,
      ST_READ = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic execute;
      logic fetch;
   } cmd_type;

endpackage

// File: sv/cdq_ctrl.sv
// Controller state machine of the circular deque.
`timescale 1ns / 1ps

module cdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output cdq_pkg::cmd_type cmd
);

   cdq_pkg::state_type state_ff;
   cdq_pkg::state_type state_in;
   logic               accept;

   // Take a beat when idle or while the previous result is shown
   assign busy   = (state_ff != cdq_pkg::ST_IDLE) && (state_ff != cdq_pkg::ST_RESP);
   assign accept = start && !busy;

   // Sequence one beat through update, read and result
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (accept) state_in = cdq_pkg::ST_OP;
         end
         cdq_pkg::ST_OP:   state_in = cdq_pkg::ST_READ;
         cdq_pkg::ST_READ: state_in = cdq_pkg::ST_RESP;
         cdq_pkg::ST_RESP: begin
            state_in = accept ? cdq_pkg::ST_OP : cdq_pkg::ST_IDLE;
         end
         default:          state_in = cdq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Drive commands and the result strobe
   assign cmd.load    = accept;
   assign cmd.execute = (state_ff == cdq_pkg::ST_OP);
   assign cmd.fetch   = (state_ff == cdq_pkg::ST_READ);
   assign rsp_valid   = (state_ff == cdq_pkg::ST_RESP);

endmodule

// File: sv/cdq_datapath.sv
// Datapath of the circular deque: entry store, indices, occupancy and result fields.
`timescale 1ns / 1ps
`include "circular_deque_top_assert.svh"

module cdq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cdq_pkg::cmd_type                    cmd,
   input  logic [cdq_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [cdq_pkg::DATA_W-1:0]   req_data,
   output logic signed [cdq_pkg::DATA_W-1:0]   rsp_popped_value,
   output logic [cdq_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic signed [cdq_pkg::DATA_W-1:0]   rsp_head_value,
   output logic signed [cdq_pkg::DATA_W-1:0]   rsp_tail_value
);

   localparam logic [cdq_pkg::IDX_W-1:0] IDX_LAST  = cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
   localparam logic [cdq_pkg::CNT_W-1:0] CNT_FULL  = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);

   logic [cdq_pkg::DATA_W-1:0] mem [cdq_pkg::DEPTH];

   logic [cdq_pkg::KIND_W-1:0]   kind_ff;
   logic [cdq_pkg::DATA_W-1:0]   data_ff;
   logic [cdq_pkg::IDX_W-1:0]    head_ff, head_in;
   logic [cdq_pkg::IDX_W-1:0]    tail_ff, tail_in;
   logic [cdq_pkg::CNT_W-1:0]    occ_ff, occ_in;
   logic [cdq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         pop_ok_ff, pop_ok_in;
   logic [cdq_pkg::DATA_W-1:0]   rd_a_ff, rd_b_ff;
   logic [cdq_pkg::DATA_W-1:0]   popped_ff;

   logic                         is_push, is_pop, is_empty, is_full;
   logic                         wr_en;
   logic [cdq_pkg::IDX_W-1:0]    wr_addr, rd_a_addr;
   logic [cdq_pkg::IDX_W-1:0]    head_prev, head_next, tail_prev, tail_next;

   // Hold the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         data_ff <= req_data;
      end
   end

   // Decode the operation and the wrapped neighbors of both indices
   assign is_push   = (kind_ff == cdq_pkg::KIND_PUSH_HEAD) || (kind_ff == cdq_pkg::KIND_PUSH_TAIL);
   assign is_pop    = (kind_ff == cdq_pkg::KIND_POP_HEAD) || (kind_ff == cdq_pkg::KIND_POP_TAIL);
   assign is_empty  = (occ_ff == '0);
   assign is_full   = (occ_ff == CNT_FULL);
   assign head_prev = (head_ff == '0) ? IDX_LAST : head_ff - 1'b1;
   assign head_next = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? IDX_LAST : tail_ff - 1'b1;
   assign tail_next = (tail_ff == IDX_LAST) ? '0 : tail_ff + 1'b1;

   // Update indices and occupancy, pick the write slot and status
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      if (cmd.execute) begin
         status_in = cdq_pkg::STATUS_OK;
         pop_ok_in = 1'b0;
         if (is_push) begin
            if (is_full) begin
               status_in = cdq_pkg::STATUS_FULL;
            end else begin
               wr_en  = 1'b1;
               occ_in = occ_ff + 1'b1;
               if (is_empty) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (kind_ff == cdq_pkg::KIND_PUSH_HEAD) begin
                  head_in = head_prev;
                  wr_addr = head_prev;
               end else begin
                  tail_in = tail_next;
                  wr_addr = tail_next;
               end
            end
         end else if (is_pop) begin
            if (is_empty) begin
               status_in = cdq_pkg::STATUS_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               occ_in    = occ_ff - 1'b1;
               if (occ_ff == cdq_pkg::CNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (kind_ff == cdq_pkg::KIND_POP_HEAD) begin
                  head_in = head_next;
               end else begin
                  tail_in = tail_prev;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         occ_ff    <= '0;
         status_ff <= cdq_pkg::STATUS_OK;
         pop_ok_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   // Read the popped entry during the update, then head and tail
   assign rd_a_addr = (cmd.execute && (kind_ff == cdq_pkg::KIND_POP_TAIL)) ? tail_ff : head_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= data_ff;
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[tail_ff];
   end

   // Capture the popped value before port A moves on to the head
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         if (pop_ok_ff) begin
            popped_ff <= rd_a_ff;
         end else if (status_ff == cdq_pkg::STATUS_EMPTY) begin
            popped_ff <= '1;
         end else begin
            popped_ff <= '0;
         end
      end
   end

   // Drive the result fields
   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_is_empty     = is_empty;
   assign rsp_is_full      = is_full;
   assign rsp_head_value   = is_empty ? '1 : rd_a_ff;
   assign rsp_tail_value   = is_empty ? '1 : rd_b_ff;

   `CDQ_ASSERT_SAME(a_occ_range, 1'b1, occ_ff <= CNT_FULL)
   `CDQ_ASSERT_SAME(a_empty_home, is_empty, (head_ff == '0) && (tail_ff == '0))
   `CDQ_ASSERT_SAME(a_single_same, occ_ff == cdq_pkg::CNT_W'(1), head_ff == tail_ff)
   `CDQ_ASSERT_NEXT(a_occ_hold, !cmd.execute, $stable(occ_ff) && $stable(head_ff))

endmodule

// File: sv/circular_deque_top.sv
// Top level of the circular deque: controller plus datapath.
//
//   channel  ports                             handshake
//   request  req_kind, req_data                start high and busy low at a clock edge
//   result   rsp_popped_value .. rsp_tail_value rsp_valid high for one cycle
//
// An item passes the update state (indices updated, store written or read),
// the read state (head and tail entries read through the store's two read
// ports) and the result state, in which the next start is already taken.
// Reset clears indices and occupancy at once; the store is not cleared.
// The receiver cannot stall; the result is shown for exactly one cycle.
`timescale 1ns / 1ps

module circular_deque_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cdq_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [cdq_pkg::DATA_W-1:0]   req_data,
   output logic                                rsp_valid,
   output logic signed [cdq_pkg::DATA_W-1:0]   rsp_popped_value,
   output logic [cdq_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic signed [cdq_pkg::DATA_W-1:0]   rsp_head_value,
   output logic signed [cdq_pkg::DATA_W-1:0]   rsp_tail_value
);

   cdq_pkg::cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   cdq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_kind),
      .req_data         (req_data),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .rsp_head_value   (rsp_head_value),
      .rsp_tail_value   (rsp_tail_value)
   );

endmodule

// File: verif/circular_deque_top_tb.sv
// Self-checking circular deque testbench: directed cases, then random operation bursts against a predictor.
`timescale 1ns / 1ps

module circular_deque_top_tb;
   import cdq_pkg::*;

   // Peek code and the top of the unused codes, which also act as peeks
   localparam logic [KIND_W-1:0] KIND_PEEK = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LAST = 3'd7;

   localparam int RANDOM_OPS   = 1200;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 12;
   localparam int REPORT_MAX   = 10;

   localparam logic signed [DATA_W-1:0] WORD_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] WORD_MIN   = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_ONES  = -32'sd1;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] data;
      bit                       drain;   // wait for every outstanding result first
   } deque_op_t;

   typedef struct {
      logic signed [DATA_W-1:0] popped;
      logic [STATUS_W-1:0]      status;
      logic                     empty;
      logic                     full;
      logic signed [DATA_W-1:0] head;
      logic signed [DATA_W-1:0] tail;
   } deque_outcome_t;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [KIND_W-1:0]          req_kind = '0;
   logic signed [DATA_W-1:0]   req_data = '0;
   logic                       rsp_valid;
   logic signed [DATA_W-1:0]   rsp_popped_value;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_is_empty;
   logic                       rsp_is_full;
   logic signed [DATA_W-1:0]   rsp_head_value;
   logic signed [DATA_W-1:0]   rsp_tail_value;

   // Predictor state
   logic signed [DATA_W-1:0]   shadow_store [DEPTH];
   logic [IDX_W-1:0]           shadow_head = '0;
   logic [IDX_W-1:0]           shadow_tail = '0;
   int unsigned                shadow_count = 0;

   deque_op_t                  queued_ops[$];
   deque_outcome_t             pending_outcomes[$];

   int unsigned cycle_count    = 0;
   int unsigned in_flight      = 0;
   int unsigned burst_left     = 0;
   int unsigned gap_left       = 0;
   int unsigned mismatch_count = 0;
   int unsigned result_count   = 0;
   int unsigned push_count     = 0;
   int unsigned pop_count      = 0;
   int unsigned peek_count     = 0;
   int unsigned full_refusals  = 0;
   int unsigned empty_refusals = 0;

   circular_deque_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .rsp_head_value   (rsp_head_value),
      .rsp_tail_value   (rsp_tail_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
   endfunction

   // Apply one operation to the shadow deque and return what the block must report
   function automatic deque_outcome_t apply_deque_op(input logic [KIND_W-1:0] kind,
                                                     input logic signed [DATA_W-1:0] value);
      deque_outcome_t res;
      bit             is_push;
      bit             is_pop;
      res.popped = '0;
      res.status = STATUS_OK;
      is_push = (kind == KIND_PUSH_HEAD) || (kind == KIND_PUSH_TAIL);
      is_pop  = (kind == KIND_POP_HEAD) || (kind == KIND_POP_TAIL);
      if (is_push) begin
         if (shadow_count >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            // An empty deque restarts both indices at entry zero
            if (shadow_count == 0) begin
               shadow_head = '0;
               shadow_tail = '0;
               shadow_store[0] = value;
            end else if (kind == KIND_PUSH_HEAD) begin
               shadow_head = wrap_down(shadow_head);
               shadow_store[shadow_head] = value;
            end else begin
               shadow_tail = wrap_up(shadow_tail);
               shadow_store[shadow_tail] = value;
            end
            shadow_count++;
         end
      end else if (is_pop) begin
         if (shadow_count == 0) begin
            res.status = STATUS_EMPTY;
            res.popped = WORD_ONES;
         end else begin
            res.popped = (kind == KIND_POP_HEAD) ? shadow_store[shadow_head]
                                                 : shadow_store[shadow_tail];
            shadow_count--;
            // Last entry gone: return both indices to zero
            if (shadow_count == 0) begin
               shadow_head = '0;
               shadow_tail = '0;
            end else if (kind == KIND_POP_HEAD) begin
               shadow_head = wrap_up(shadow_head);
            end else begin
               shadow_tail = wrap_down(shadow_tail);
            end
         end
      end
      res.empty = (shadow_count == 0);
      res.full  = (shadow_count >= DEPTH);
      res.head  = res.empty ? WORD_ONES : shadow_store[shadow_head];
      res.tail  = res.empty ? WORD_ONES : shadow_store[shadow_tail];
      return res;
   endfunction

   function automatic void add_op(input logic [KIND_W-1:0] kind,
                                  input logic signed [DATA_W-1:0] data,
                                  input bit drain = 1'b0);
      deque_op_t op;
      op.kind  = kind;
      op.data  = data;
      op.drain = drain;
      queued_ops.push_back(op);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return WORD_ONES;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
      end
   endtask

   // Build the stimulus: directed corner cases, then random phases
   initial begin : build_stimulus
      int unsigned                added;
      int unsigned                phase_len;
      int unsigned                push_pct;
      int unsigned                roll;
      logic [KIND_W-1:0]          kind;
      bit                         drain;
      // Empty deque: peek, and both pops refused
      add_op(KIND_PEEK, $urandom);
      add_op(KIND_POP_HEAD, $urandom);
      add_op(KIND_POP_TAIL, $urandom);
      // Push head into empty, then tail; pop tail then head down to empty
      add_op(KIND_PUSH_HEAD, WORD_MAX);
      add_op(KIND_PUSH_TAIL, WORD_MIN);
      add_op(KIND_PEEK, '0);
      add_op(KIND_POP_TAIL, '0);
      add_op(KIND_POP_HEAD, '0);
      // Push tail into empty, head push wraps below entry zero, then fill up
      add_op(KIND_PUSH_TAIL, '0);
      add_op(KIND_PUSH_HEAD, WORD_ONES);
      for (int i = 0; i < DEPTH - 2; i++)
         add_op(KIND_PUSH_TAIL, $urandom);
      // Full deque: both pushes refused
      add_op(KIND_PUSH_HEAD, $urandom);
      add_op(KIND_PUSH_TAIL, $urandom);
      // Unused codes behave as peeks
      for (int k = KIND_PEEK + 1; k <= KIND_LAST; k++)
         add_op(KIND_W'(k), $urandom);
      add_op(KIND_POP_HEAD, '0);
      add_op(KIND_POP_TAIL, '0);

      // Random phases that lean toward filling, draining or neither
      added = 0;
      while (added < RANDOM_OPS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(2))
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
         endcase
         drain = (added == 0) || ($urandom_range(3) == 0);
         for (int i = 0; i < phase_len && added < RANDOM_OPS; i++) begin
            roll = $urandom_range(99);
            if (roll < 8)
               kind = KIND_W'($urandom_range(KIND_PEEK, KIND_LAST));
            else if ($urandom_range(99) < push_pct)
               kind = $urandom_range(1) ? KIND_PUSH_HEAD : KIND_PUSH_TAIL;
            else
               kind = $urandom_range(1) ? KIND_POP_HEAD : KIND_POP_TAIL;
            add_op(kind, pick_value(), drain && (i == 0));
            added++;
         end
      end
   end

   // Driver: present queued operations in bursts, holding each until accepted
   always @(posedge clock) begin : drive_ops
      deque_op_t op;
      bit        taken;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         in_flight = in_flight + taken - rsp_valid;
         if (start && !taken) begin
            // hold the beat until the block takes it
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (queued_ops.size() != 0 && (!queued_ops[0].drain || in_flight == 0)) begin
            op = queued_ops.pop_front();
            start    <= 1'b1;
            req_kind <= op.kind;
            req_data <= op.data;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predict on each accepted beat, check each result beat
   always @(posedge clock) begin : watch_results
      deque_outcome_t want;
      if (!reset) begin
         if (rsp_valid) begin
            result_count++;
            if (pending_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: result with no operation outstanding", $realtime);
            end else begin
               want = pending_outcomes.pop_front();
               check_field("popped_value", want.popped, rsp_popped_value);
               check_field("status", DATA_W'(want.status), DATA_W'(rsp_status));
               check_field("is_empty", DATA_W'(want.empty), DATA_W'(rsp_is_empty));
               check_field("is_full", DATA_W'(want.full), DATA_W'(rsp_is_full));
               check_field("head_value", want.head, rsp_head_value);
               check_field("tail_value", want.tail, rsp_tail_value);
            end
         end
         if (start && !busy) begin
            want = apply_deque_op(req_kind, req_data);
            pending_outcomes.push_back(want);
            if (want.status == STATUS_FULL) full_refusals++;
            if (want.status == STATUS_EMPTY) empty_refusals++;
            if (req_kind == KIND_PUSH_HEAD || req_kind == KIND_PUSH_TAIL) push_count++;
            else if (req_kind == KIND_POP_HEAD || req_kind == KIND_POP_TAIL) pop_count++;
            else peek_count++;
         end
      end
   end

   // Run control: reset, wait for all beats to drain, then report
   initial begin : run_control
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (!(queued_ops.size() == 0 && !start && in_flight == 0)
             && cycle_count < CYCLE_LIMIT)
         @(negedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
      end else begin
         repeat (SETTLE_TICKS) @(negedge clock);
         if (pending_outcomes.size() != 0) begin
            mismatch_count++;
            $display("%0d operations never produced a result", pending_outcomes.size());
         end
         $display("Checked %0d results: %0d pushes, %0d pops, %0d peeks",
                  result_count, push_count, pop_count, peek_count);
         $display("Refused %0d pushes at full and %0d pops at empty; %0d mismatches",
                  full_refusals, empty_refusals, mismatch_count);
         if (mismatch_count == 0) begin
            $display("Test completed successfully");
         end else begin
            $display("Test completed with failures");
         end
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/cdq_pkg.sv
sv/cdq_ctrl.sv
sv/cdq_datapath.sv
sv/circular_deque_top.sv
verif/circular_deque_top_tb.sv
